// ===== src/sbng_pkg.sv =====
// sbng_pkg: constants and types for the seeded bf16 noise generator
// no dependencies

package sbng_pkg;

    localparam logic [63:0] SEED_MUL_KIND  = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SEED_MUL_LAYER = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SEED_ZERO_FIX  = 64'h2545f4914f6cdd1d;
    localparam logic [63:0] STAR_MUL       = 64'h2545f4914f6cdd1d;
    localparam logic [15:0] NOISE_ZERO     = 16'h8000;
    localparam logic [7:0]  EXP_BIAS_OFS   = 8'd107;

    localparam logic MODE_START    = 1'b0;
    localparam logic MODE_GENERATE = 1'b1;

    // seed partial products, low 32 bits of each factor apart
    typedef struct packed {
        logic        mode;
        logic [63:0] kind_lo;
        logic [31:0] kind_hi;
        logic [63:0] layer_lo;
        logic [31:0] layer_hi;
    } seed_parts_t;

endpackage

// ===== src/sbng_in_if.sv =====
// sbng_in_if: input item channel
// depends on nothing

interface sbng_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] kind_id;
    logic [31:0] layer_id;

    modport source (output valid, output mode, output kind_id, output layer_id,
                    input ready);
    modport sink (input valid, input mode, input kind_id, input layer_id,
                  output ready);
endinterface

// ===== src/sbng_out_if.sv =====
// sbng_out_if: result item channel
// depends on nothing

interface sbng_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] bf16_value;

    modport source (output valid, output bf16_value, input ready);
    modport sink (input valid, input bf16_value, output ready);
endinterface

// ===== src/sbng_cfg_if.sv =====
// sbng_cfg_if: base seed write channel
// depends on nothing

interface sbng_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] base_seed;

    modport source (output valid, output base_seed, input ready);
    modport sink (input valid, input base_seed, output ready);
endinterface

// ===== src/sbng_seed_mul.sv =====
// sbng_seed_mul: registered 32x32 partial products of the seed terms
// depends on sbng_pkg

module sbng_seed_mul
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  valid_in,
    input  logic                  mode_in,
    input  logic [31:0]           kind1,
    input  logic [31:0]           layer1,
    output logic                  valid_out,
    output sbng_pkg::seed_parts_t parts_out
);

    logic                  valid_reg;
    sbng_pkg::seed_parts_t parts_reg;
    sbng_pkg::seed_parts_t parts_next;

    always_comb
    begin
        parts_next.mode     = mode_in;
        parts_next.kind_lo  = {32'd0, sbng_pkg::SEED_MUL_KIND[31:0]} * {32'd0, kind1};
        parts_next.kind_hi  = sbng_pkg::SEED_MUL_KIND[63:32] * kind1;
        parts_next.layer_lo = {32'd0, sbng_pkg::SEED_MUL_LAYER[31:0]} * {32'd0, layer1};
        parts_next.layer_hi = sbng_pkg::SEED_MUL_LAYER[63:32] * layer1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            parts_reg <= parts_next;
        end
    end

    assign valid_out = valid_reg;
    assign parts_out = parts_reg;

endmodule

// ===== src/sbng_state.sv =====
// sbng_state: generator state, seeding and xorshift64 step
// depends on sbng_pkg

module sbng_state
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  valid_in,
    input  sbng_pkg::seed_parts_t parts_in,
    input  logic [63:0]           base_seed,
    output logic                  valid_out,
    output logic [15:0]           sample_out
);

    logic [63:0] state_reg;
    logic [63:0] state_next;
    logic [63:0] seed;
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic        valid_reg;
    logic [15:0] sample_reg;

    always_comb
    begin
        seed = base_seed
             ^ (parts_in.kind_lo + {parts_in.kind_hi, 32'd0})
             ^ (parts_in.layer_lo + {parts_in.layer_hi, 32'd0});
        if (seed == 64'd0)
        begin
            seed = sbng_pkg::SEED_ZERO_FIX;
        end
        v0 = state_reg ^ (state_reg >> 12);
        v1 = v0 ^ (v0 << 25);
        v2 = v1 ^ (v1 >> 27);
        state_next = (parts_in.mode == sbng_pkg::MODE_START) ? seed : v2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= 64'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in && (parts_in.mode == sbng_pkg::MODE_GENERATE);
            if (valid_in)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= v2[15:0];
        end
    end

    assign valid_out  = valid_reg;
    assign sample_out = sample_reg;

endmodule

// ===== src/sbng_out_stage.sv =====
// sbng_out_stage: star multiply low bits, bf16 conversion, result register
// depends on sbng_pkg and sbng_out_if

module sbng_out_stage
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic [15:0] sample_in,
    output logic        load,
    sbng_out_if.source  rsp
);

    logic        valid_reg;
    logic [15:0] value_reg;
    logic [15:0] value_next;
    logic [15:0] x;
    logic [15:0] mag;
    logic [15:0] norm;
    logic [3:0]  msb;
    logic        sign;

    always_comb
    begin
        x = sample_in * sbng_pkg::STAR_MUL[15:0];
        sign = (x < sbng_pkg::NOISE_ZERO);
        mag = sign ? (sbng_pkg::NOISE_ZERO - x) : (x - sbng_pkg::NOISE_ZERO);
        msb = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (mag[i])
            begin
                msb = 4'(i);
            end
        end
        norm = mag << (4'd15 - msb);
        if (x == sbng_pkg::NOISE_ZERO)
        begin
            value_next = 16'd0;
        end
        else
        begin
            value_next = {sign, sbng_pkg::EXP_BIAS_OFS + {4'd0, msb}, norm[14:8]};
        end
    end

    assign load = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= value_next;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.bf16_value = value_reg;

endmodule

// ===== src/seeded_bf16_noise_generator.sv =====
// seeded_bf16_noise_generator: top level, input register and stage chaining
// depends on sbng_pkg, the channel interfaces and the three stage modules
//
//  channel | dir | payload
//  cfg     | in  | base_seed (64)
//  req     | in  | mode, kind_id, layer_id
//  rsp     | out | bf16_value
//
// one item per cycle while rsp is not stalled; four register stages from req to rsp
// start items leave no result
// reset clears the state to zero and base_seed to one
// a stalled rsp holds its result while bubbles in the stages still fill

module seeded_bf16_noise_generator
(
    input  logic       clk,
    input  logic       rst_n,
    sbng_cfg_if.sink   cfg,
    sbng_in_if.sink    req,
    sbng_out_if.source rsp
);

    logic                  en_a;
    logic                  en_b;
    logic                  en_c;
    logic                  en_d;
    logic                  valid_a_reg;
    logic                  mode_a_reg;
    logic [31:0]           kind1_a_reg;
    logic [31:0]           layer1_a_reg;
    logic [63:0]           base_seed_reg;
    logic                  valid_b;
    sbng_pkg::seed_parts_t parts_b;
    logic                  valid_c;
    logic [15:0]           sample_c;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_seed_reg <= 64'd1;
        end
        else if (cfg.valid)
        begin
            base_seed_reg <= cfg.base_seed;
        end
    end

    assign en_c = !valid_c || en_d;
    assign en_b = !valid_b || en_c;
    assign en_a = !valid_a_reg || en_b;
    assign req.ready = en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (en_a)
        begin
            valid_a_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            mode_a_reg   <= req.mode;
            kind1_a_reg  <= req.kind_id + 32'd1;
            layer1_a_reg <= req.layer_id + 32'd1;
        end
    end

    sbng_seed_mul u_seed_mul
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (en_b),
        .valid_in  (valid_a_reg),
        .mode_in   (mode_a_reg),
        .kind1     (kind1_a_reg),
        .layer1    (layer1_a_reg),
        .valid_out (valid_b),
        .parts_out (parts_b)
    );

    sbng_state u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (en_c),
        .valid_in   (valid_b),
        .parts_in   (parts_b),
        .base_seed  (base_seed_reg),
        .valid_out  (valid_c),
        .sample_out (sample_c)
    );

    sbng_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid_c),
        .sample_in (sample_c),
        .load      (en_d),
        .rsp       (rsp)
    );

endmodule

// ===== tb/sv/tb_seeded_bf16_noise_generator.sv =====
// tb_seeded_bf16_noise_generator: random and directed test of the bf16 noise generator
// predicts each value from its own xorshift64* model and checks every result item in order
// depends on sbng_pkg, the top level and the req, rsp and cfg channel interfaces

`timescale 1ns / 1ps

module tb_seeded_bf16_noise_generator;

    typedef struct packed {
        logic        mode;
        logic [31:0] kind;
        logic [31:0] layer;
    } noise_req_t;

    logic clk;
    logic rst_n;

    sbng_cfg_if cfg ();
    sbng_in_if  req ();
    sbng_out_if rsp ();

    seeded_bf16_noise_generator i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    noise_req_t  pending_reqs[$];
    logic [15:0] expected_values[$];
    logic [63:0] model_seed;
    logic [63:0] model_state;
    int          mismatches;
    int          req_gap;
    int          rsp_gap;
    int          hold_cycles;

    function automatic logic [15:0] sample_to_bf16(input logic [15:0] x);
        logic        sgn;
        logic [16:0] mag;
        int          e;
        logic [31:0] bits;
        if (x == 16'h8000)
            return 16'h0000;
        sgn = (x < 16'h8000);
        mag = sgn ? (17'd32768 - x) : ({1'b0, x} - 17'd32768);
        e = 0;
        while (e < 16 && (mag >> (e + 1)) != 0)
            e++;
        bits = {sgn, 8'(e + 107), 23'((32'(mag) << (23 - e)) & 32'h7fffff)};
        return bits[31:16];
    endfunction

    task automatic predict_noise(input noise_req_t it);
        logic [63:0] s;
        logic [63:0] v;
        logic [63:0] r;
        if (it.mode == sbng_pkg::MODE_START)
        begin
            s = model_seed ^ (sbng_pkg::SEED_MUL_KIND * 64'(32'(it.kind + 32'd1)))
                ^ (sbng_pkg::SEED_MUL_LAYER * 64'(32'(it.layer + 32'd1)));
            model_state = (s == 64'd0) ? sbng_pkg::SEED_ZERO_FIX : s;
        end
        else
        begin
            v = model_state;
            v ^= v >> 12;
            v ^= v << 25;
            v ^= v >> 27;
            model_state = v;
            r = v * sbng_pkg::STAR_MUL;
            expected_values.push_back(sample_to_bf16(r[15:0]));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.mode <= 1'b0;
            req.kind_id <= '0;
            req.layer_id <= '0;
            req_gap = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_noise({req.mode, req.kind_id, req.layer_id});
                void'(pending_reqs.pop_front());
                req_gap = $urandom_range(0, 8);
                if ($urandom_range(0, 3) == 0)
                    req_gap = 0;
            end
            if (req.valid && !req.ready)
                ;
            else if (pending_reqs.size() != 0 && req_gap == 0)
            begin
                req.valid <= 1'b1;
                req.mode <= pending_reqs[0].mode;
                req.kind_id <= pending_reqs[0].kind;
                req.layer_id <= pending_reqs[0].layer;
            end
            else
            begin
                req.valid <= 1'b0;
                if (req_gap > 0)
                    req_gap--;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_gap = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: bf16_value %h", rsp.bf16_value);
                end
                else
                begin
                    if (rsp.bf16_value !== expected_values[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h, actual %h",
                                     expected_values[0], rsp.bf16_value);
                    end
                    void'(expected_values.pop_front());
                end
                rsp_gap = $urandom_range(0, 8);
                if ($urandom_range(0, 3) == 0)
                    rsp_gap = 0;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp.ready <= 1'b0;
            end
            else if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    task automatic add_req(input logic mode, input logic [31:0] kind,
                           input logic [31:0] layer);
        pending_reqs.push_back('{mode, kind, layer});
    endtask

    task automatic drain_all();
        while (pending_reqs.size() != 0 || req.valid || expected_values.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] seed);
        cfg.valid <= 1'b1;
        cfg.base_seed <= seed;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        model_seed = seed;
        cfg.valid <= 1'b0;
    endtask

    task automatic add_random_stream();
        int n;
        add_req(sbng_pkg::MODE_START, $urandom, $urandom);
        n = $urandom_range(1, 20);
        repeat (n)
            add_req(sbng_pkg::MODE_GENERATE, $urandom, $urandom);
    endtask

    initial
    begin
        logic [63:0] seeds[4];
        int phase;
        mismatches = 0;
        hold_cycles = 0;
        model_seed = 64'd1;
        model_state = 64'd0;
        cfg.valid = 1'b0;
        cfg.base_seed = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // generate before any start, then field extremes
        add_req(sbng_pkg::MODE_GENERATE, 32'hffffffff, 32'h0);
        add_req(sbng_pkg::MODE_GENERATE, 32'h0, 32'hffffffff);
        add_req(sbng_pkg::MODE_START, 32'h0, 32'h0);
        repeat (3) add_req(sbng_pkg::MODE_GENERATE, 32'h0, 32'h0);
        add_req(sbng_pkg::MODE_START, 32'hffffffff, 32'hffffffff);
        repeat (3) add_req(sbng_pkg::MODE_GENERATE, 32'hffffffff, 32'hffffffff);
        add_req(sbng_pkg::MODE_START, 32'hffffffff, 32'h0);
        add_req(sbng_pkg::MODE_GENERATE, 32'h0, 32'h0);
        add_req(sbng_pkg::MODE_START, 32'h0, 32'hffffffff);
        add_req(sbng_pkg::MODE_GENERATE, 32'h0, 32'h0);
        drain_all();

        // kind and layer both wrap to zero: the seed equals base_seed, zero gets replaced
        write_seed(64'd0);
        add_req(sbng_pkg::MODE_START, 32'hffffffff, 32'hffffffff);
        repeat (3) add_req(sbng_pkg::MODE_GENERATE, 32'h0, 32'h0);
        drain_all();

        seeds[0] = 64'hffffffffffffffff;
        seeds[1] = {$urandom, $urandom};
        seeds[2] = 64'd1;
        seeds[3] = {$urandom, $urandom};
        for (phase = 0; phase < 4; phase++)
        begin
            write_seed(seeds[phase]);
            while (pending_reqs.size() < 300)
                add_random_stream();
            if (phase == 1)
                hold_cycles = 200;
            drain_all();
        end
        if (mismatches == 0)
            $display("tb_seeded_bf16_noise_generator OK");
        else
            $display("tb_seeded_bf16_noise_generator NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb_seeded_bf16_noise_generator NOT OK");
        $finish;
    end
endmodule
